// File: rtl/core/fsp_pkg.sv
package fsp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int TICK_W    = 32;
  localparam int DFT_W     = 24;
  localparam int SKIP_W    = 5;
  localparam int DIV_BITS  = TICK_W + FRAC_BITS;
  localparam int K_W       = FRAC_BITS + 1;
  localparam int PROD_W    = 32 + K_W;

  localparam logic [K_W-1:0] KI_Q   = K_W'(((64'd55 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [K_W-1:0] KD_Q   = K_W'(((64'd4  << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [K_W-1:0] LEAK_Q = K_W'(((64'd99 << FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic [TICK_W-1:0] TICK_RATE_RST = 32'd1000;
  localparam logic [DFT_W-1:0]  DFT_RST       = 24'd280433;
  localparam logic [SKIP_W-1:0] MIN_SKIP_RST  = 5'd0;
  localparam logic [SKIP_W-1:0] MAX_SKIP_RST  = 5'd9;

  typedef enum logic [1:0] {
    REG_TICK_RATE = 2'd0,
    REG_DFT       = 2'd1,
    REG_MIN_SKIP  = 2'd2,
    REG_MAX_SKIP  = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_E, OP_GET_E, OP_DIV_U, OP_GET_U, OP_DIV_D, OP_GET_D,
    OP_MUL_ED, OP_ACC_I, OP_MUL_IL, OP_LEAK, OP_MUL_DK, OP_ADD_P, OP_MUL_IK,
    OP_ADJ, OP_LEVEL, OP_UP, OP_DN, OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic diff_zero;
    logic up_ok;
    logic dn_ok;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/core/fsp_if.sv
interface fsp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] elapsed_ticks;
  logic [31:0] unthrottled_ticks;
  logic        restart;
  modport source (output valid, elapsed_ticks, unthrottled_ticks, restart, input ready);
  modport sink (input valid, elapsed_ticks, unthrottled_ticks, restart, output ready);
endinterface

interface fsp_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] skip_count;
  logic       release_throttle;
  modport source (output valid, skip_count, release_throttle, input ready);
  modport sink (input valid, skip_count, release_throttle, output ready);
endinterface

// File: rtl/core/fsp_cfg.sv
module fsp_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output logic [fsp_pkg::TICK_W-1:0]         tick_rate,
  output logic [fsp_pkg::DFT_W-1:0]          desired_frame_time,
  output logic [fsp_pkg::SKIP_W-1:0]         min_skip,
  output logic [fsp_pkg::SKIP_W-1:0]         max_skip
);
  logic [fsp_pkg::TICK_W-1:0] tick_rate_r;
  logic [fsp_pkg::DFT_W-1:0]  dft_r;
  logic [fsp_pkg::SKIP_W-1:0] min_r, max_r;
  logic                       wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= fsp_pkg::TICK_RATE_RST;
      dft_r       <= fsp_pkg::DFT_RST;
      min_r       <= fsp_pkg::MIN_SKIP_RST;
      max_r       <= fsp_pkg::MAX_SKIP_RST;
    end else if (wr) begin
      case (fsp_pkg::reg_idx_t'(paddr[3:2]))
        fsp_pkg::REG_TICK_RATE: tick_rate_r <= pwdata;
        fsp_pkg::REG_DFT:       dft_r <= pwdata[fsp_pkg::DFT_W-1:0];
        fsp_pkg::REG_MIN_SKIP:  min_r <= pwdata[fsp_pkg::SKIP_W-1:0];
        fsp_pkg::REG_MAX_SKIP:  max_r <= pwdata[fsp_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fsp_pkg::reg_idx_t'(paddr[3:2]))
      fsp_pkg::REG_TICK_RATE: prdata = tick_rate_r;
      fsp_pkg::REG_DFT:       prdata = {8'd0, dft_r};
      fsp_pkg::REG_MIN_SKIP:  prdata = {27'd0, min_r};
      fsp_pkg::REG_MAX_SKIP:  prdata = {27'd0, max_r};
      default:                prdata = '0;
    endcase
  end

  assign tick_rate          = tick_rate_r;
  assign desired_frame_time = dft_r;
  assign min_skip           = min_r;
  assign max_skip           = max_r;
endmodule

// File: rtl/core/fsp_div.sv
module fsp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   num,
  input  logic [31:0]                   den,
  output logic                          busy,
  output logic [fsp_pkg::DIV_BITS-1:0]  quo
);
  localparam int CNT_W = $clog2(fsp_pkg::DIV_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(fsp_pkg::DIV_BITS - 1);

  logic                         busy_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [32:0]                  rem_r;
  logic [fsp_pkg::DIV_BITS-1:0] dq_r;
  logic [31:0]                  den_r;
  logic [32:0]                  rem_sh, rem_nxt;
  logic                         ge;

  always_comb begin
    rem_sh  = {rem_r[31:0], dq_r[fsp_pkg::DIV_BITS-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= {num, {fsp_pkg::FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[fsp_pkg::DIV_BITS-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = dq_r;
endmodule

// File: rtl/core/fsp_dp.sv
module fsp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fsp_pkg::cmd_t               cmd,
  output fsp_pkg::sts_t               sts,
  input  logic [31:0]                 elapsed_ticks,
  input  logic [31:0]                 unthrottled_ticks,
  input  logic                        restart,
  input  logic [fsp_pkg::TICK_W-1:0]  tick_rate,
  input  logic [fsp_pkg::DFT_W-1:0]   desired_frame_time,
  input  logic [fsp_pkg::SKIP_W-1:0]  min_skip,
  input  logic [fsp_pkg::SKIP_W-1:0]  max_skip,
  output logic [fsp_pkg::SKIP_W-1:0]  skip_count,
  output logic                        release_throttle
);
  localparam int F = fsp_pkg::FRAC_BITS;
  localparam logic signed [27:0] RES_ONE = 28'sd1 <<< F;
  localparam logic signed [27:0] RES_LIM = 28'sd4 <<< F;

  logic [31:0]                  el_r, un_r;
  logic [F:0]                   diff_r;
  logic signed [25:0]           err_r, perr_r;
  logic signed [31:0]           der_r, int_r, sl_r;
  logic signed [27:0]           res_r;
  logic signed [8:0]            rv_r;
  logic signed [33:0]           acc_r;
  logic                         rel_r;
  logic [fsp_pkg::SKIP_W-1:0]   pskip_r, skip_r;
  logic                         relo_r;
  logic [fsp_pkg::PROD_W-1:0]   prod_r;
  logic                         pneg_r;

  logic [31:0]                  rate_eff, div_num, div_den;
  logic                         div_busy;
  logic [fsp_pkg::DIV_BITS-1:0] quo;
  logic signed [26:0]           dnum, err_raw;
  logic [26:0]                  dmag;
  logic [25:0]                  usec;
  logic [30:0]                  dq;
  logic signed [31:0]           mul_a;
  logic [31:0]                  mul_mag;
  logic [fsp_pkg::K_W-1:0]      mul_k;
  logic [fsp_pkg::PROD_W-1:0]   prod_rnd;
  logic signed [33:0]           rnd;
  logic signed [33:0]           e40;
  logic signed [34:0]           adj;
  logic signed [31:0]           sl_new;
  logic [31:0]                  sl_mag;
  logic signed [8:0]            rv_lvl, rv_min, rv_max, rv_c, pskip_s;
  logic signed [27:0]           frac;
  logic signed [31:0]           lo, hi;

  assign rate_eff = (tick_rate == '0) ? 32'd1 : tick_rate;
  assign dnum = $signed({err_r[25], err_r}) - $signed({perr_r[25], perr_r});
  assign dmag = dnum[26] ? 27'(-dnum) : 27'(dnum);

  always_comb begin
    case (cmd.op)
      fsp_pkg::OP_DIV_U: begin div_num = un_r; div_den = rate_eff; end
      fsp_pkg::OP_DIV_D: begin div_num = {5'd0, dmag}; div_den = {7'd0, diff_r}; end
      default:           begin div_num = el_r; div_den = rate_eff; end
    endcase
  end

  fsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign usec    = (quo > (56'd1 << (F + 1))) ? 26'(1 << (F + 1)) : quo[25:0];
  assign err_raw = $signed({1'b0, usec}) - $signed({3'b0, desired_frame_time});
  assign dq      = (quo > 56'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo[30:0];

  always_comb begin
    case (cmd.op)
      fsp_pkg::OP_MUL_ED: begin mul_a = 32'(err_r); mul_k = diff_r; end
      fsp_pkg::OP_MUL_IL: begin mul_a = int_r; mul_k = fsp_pkg::LEAK_Q; end
      fsp_pkg::OP_MUL_DK: begin mul_a = der_r; mul_k = fsp_pkg::KD_Q; end
      default:            begin mul_a = int_r; mul_k = fsp_pkg::KI_Q; end
    endcase
    mul_mag = mul_a[31] ? 32'(-mul_a) : 32'(mul_a);
  end

  assign prod_rnd = prod_r + (fsp_pkg::PROD_W'(1) << (F - 1));
  assign rnd = pneg_r ? -$signed({1'b0, prod_rnd[fsp_pkg::PROD_W-1:F]})
                      : $signed({1'b0, prod_rnd[fsp_pkg::PROD_W-1:F]});
  assign e40 = ($signed(34'(err_r)) <<< 5) + ($signed(34'(err_r)) <<< 3);
  assign adj = $signed(35'(acc_r)) + $signed(35'(rnd));
  assign sl_new = fsp_pkg::sat32(36'(sl_r) + 36'(adj));

  assign sl_mag = sl_r[31] ? 32'(-sl_r) : 32'(sl_r);
  assign rv_lvl = sl_r[31] ? -$signed({1'b0, sl_mag[31:F]}) : $signed({1'b0, sl_mag[31:F]});
  assign frac   = sl_r[31] ? -$signed({4'd0, sl_mag[F-1:0]}) : $signed({4'd0, sl_mag[F-1:0]});

  assign rv_min  = $signed({4'd0, min_skip});
  assign rv_max  = $signed({4'd0, max_skip});
  assign pskip_s = $signed({4'd0, pskip_r});
  always_comb begin
    rv_c = rv_r;
    if (rv_c < rv_min) rv_c = rv_min;
    if (rv_c > rv_max) rv_c = rv_max;
  end
  assign lo = (32'(rv_min) - 32'sd1) <<< F;
  assign hi = (32'(rv_max) + 32'sd1) <<< F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perr_r  <= '0;
      int_r   <= '0;
      sl_r    <= '0;
      res_r   <= '0;
      pskip_r <= '0;
    end else begin
      case (cmd.op)
        fsp_pkg::OP_LOAD: begin
          if (restart) sl_r <= sl_r[31] ? -$signed(sl_mag >> 1) : $signed(sl_mag >> 1);
        end
        fsp_pkg::OP_GET_D: perr_r <= err_r;
        fsp_pkg::OP_ACC_I: int_r <= fsp_pkg::sat32(36'(int_r) + 36'(rnd));
        fsp_pkg::OP_LEAK:  int_r <= rnd[31:0];
        fsp_pkg::OP_ADJ:   sl_r <= sl_new;
        fsp_pkg::OP_LEVEL: res_r <= res_r + frac;
        fsp_pkg::OP_UP:    res_r <= res_r - RES_ONE;
        fsp_pkg::OP_DN:    res_r <= res_r + RES_ONE;
        fsp_pkg::OP_FIN: begin
          if (res_r >= RES_LIM) res_r <= RES_LIM;
          else if (res_r <= -RES_LIM) res_r <= -RES_LIM;
          if (sl_r < lo) sl_r <= (lo > hi) ? hi : lo;
          else if (sl_r > hi) sl_r <= hi;
          pskip_r <= rv_c[fsp_pkg::SKIP_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fsp_pkg::OP_LOAD: begin
        el_r <= elapsed_ticks;
        un_r <= unthrottled_ticks;
      end
      fsp_pkg::OP_GET_E: diff_r <= (quo > (56'd1 << F)) ? (F+1)'(1 << F) : quo[F:0];
      fsp_pkg::OP_GET_U: begin
        if (err_raw > (27'sd1 <<< F) || err_raw < -(27'sd1 <<< F)) err_r <= '0;
        else err_r <= err_raw[25:0];
      end
      fsp_pkg::OP_GET_D: begin
        if (diff_r == '0) der_r <= (dnum > 0) ? 32'sh7FFF_FFFF :
                                   (dnum < 0) ? -32'sh7FFF_FFFF : 32'sd0;
        else der_r <= dnum[26] ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
      end
      fsp_pkg::OP_ADD_P: acc_r <= e40 + rnd;
      fsp_pkg::OP_ADJ:   rel_r <= (adj > 0) && (sl_new > 0);
      fsp_pkg::OP_LEVEL: rv_r <= rv_lvl;
      fsp_pkg::OP_UP:    rv_r <= rv_r + 9'sd1;
      fsp_pkg::OP_DN:    rv_r <= rv_r - 9'sd1;
      fsp_pkg::OP_FIN: begin
        skip_r <= rv_c[fsp_pkg::SKIP_W-1:0];
        relo_r <= rel_r;
      end
      default: ;
    endcase
    if (cmd.op == fsp_pkg::OP_MUL_ED || cmd.op == fsp_pkg::OP_MUL_IL ||
        cmd.op == fsp_pkg::OP_MUL_DK || cmd.op == fsp_pkg::OP_MUL_IK) begin
      prod_r <= mul_mag * mul_k;
      pneg_r <= mul_a[31];
    end
  end

  assign sts.div_busy  = div_busy;
  assign sts.diff_zero = (diff_r == '0);
  assign sts.up_ok = (res_r >= RES_ONE) && (rv_r <= pskip_s) && (rv_r < rv_max);
  assign sts.dn_ok = (res_r <= -RES_ONE) && (rv_r >= pskip_s) && (rv_r > rv_min);

  assign skip_count       = skip_r;
  assign release_throttle = relo_r;

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == fsp_pkg::OP_FIN |=> (res_r <= RES_LIM) && (res_r >= -RES_LIM))
    else $error("residue out of range after finish");
endmodule

// File: rtl/core/fsp_ctrl.sv
module fsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fsp_pkg::sts_t sts,
  output fsp_pkg::cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_DE, S_WE, S_DU, S_WU, S_DD, S_WD, S_M0, S_A0, S_M1, S_A1,
    S_M2, S_A2, S_M3, S_A3, S_LV, S_UP, S_DN, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = fsp_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = fsp_pkg::OP_LOAD;
        state_nxt = S_DE;
      end
      S_DE: begin
        cmd.op = fsp_pkg::OP_DIV_E; cmd.div_start = 1'b1; state_nxt = S_WE;
      end
      S_WE: if (!sts.div_busy) begin
        cmd.op = fsp_pkg::OP_GET_E; state_nxt = S_DU;
      end
      S_DU: begin
        cmd.op = fsp_pkg::OP_DIV_U; cmd.div_start = 1'b1; state_nxt = S_WU;
      end
      S_WU: if (!sts.div_busy) begin
        cmd.op = fsp_pkg::OP_GET_U; state_nxt = S_DD;
      end
      S_DD: begin
        if (sts.diff_zero) begin
          cmd.op = fsp_pkg::OP_GET_D; state_nxt = S_M0;
        end else begin
          cmd.op = fsp_pkg::OP_DIV_D; cmd.div_start = 1'b1; state_nxt = S_WD;
        end
      end
      S_WD: if (!sts.div_busy) begin
        cmd.op = fsp_pkg::OP_GET_D; state_nxt = S_M0;
      end
      S_M0: begin cmd.op = fsp_pkg::OP_MUL_ED; state_nxt = S_A0; end
      S_A0: begin cmd.op = fsp_pkg::OP_ACC_I;  state_nxt = S_M1; end
      S_M1: begin cmd.op = fsp_pkg::OP_MUL_IL; state_nxt = S_A1; end
      S_A1: begin cmd.op = fsp_pkg::OP_LEAK;   state_nxt = S_M2; end
      S_M2: begin cmd.op = fsp_pkg::OP_MUL_DK; state_nxt = S_A2; end
      S_A2: begin cmd.op = fsp_pkg::OP_ADD_P;  state_nxt = S_M3; end
      S_M3: begin cmd.op = fsp_pkg::OP_MUL_IK; state_nxt = S_A3; end
      S_A3: begin cmd.op = fsp_pkg::OP_ADJ;    state_nxt = S_LV; end
      S_LV: begin cmd.op = fsp_pkg::OP_LEVEL;  state_nxt = S_UP; end
      S_UP: begin
        if (sts.up_ok) cmd.op = fsp_pkg::OP_UP;
        else state_nxt = S_DN;
      end
      S_DN: begin
        if (sts.dn_ok) cmd.op = fsp_pkg::OP_DN;
        else state_nxt = S_FIN;
      end
      S_FIN: if (!out_valid_r || out_ready) begin
        cmd.op = fsp_pkg::OP_FIN;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DE)
    else $error("item accepted but sequence not started");
  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WE || state_r == S_WU || state_r == S_WD) && sts.div_busy
    |-> cmd.op == fsp_pkg::OP_NONE)
    else $error("quotient taken while divider busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == fsp_pkg::OP_FIN |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");
endmodule

// File: rtl/core/frame_skip_pid_controller.sv
// Frame-skip PID controller: one input item per finished frame, one result item
// back (skip count and throttle-release flag). Each item runs three 56-step
// radix-2 divisions on one shared divider (the third skipped when the frame
// time is zero), followed by four passes through one 32x25 multiplier and up
// to four single-step residue adjustments. The next item is taken as soon as
// the sequence returns to idle, while the previous result may still wait in the
// output register; if it is still waiting when the next item is done, that item
// holds in its last step until the result is taken.
// Registers sit on an APB-style port at byte addresses 0, 4, 8 and 12.
module frame_skip_pid_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fsp_in_if.sink      in_item,
  fsp_out_if.source   out_item
);
  logic [fsp_pkg::TICK_W-1:0] tick_rate;
  logic [fsp_pkg::DFT_W-1:0]  dft;
  logic [fsp_pkg::SKIP_W-1:0] min_skip, max_skip;
  fsp_pkg::cmd_t              cmd;
  fsp_pkg::sts_t              sts;

  fsp_cfg u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .tick_rate          (tick_rate),
    .desired_frame_time (dft),
    .min_skip           (min_skip),
    .max_skip           (max_skip)
  );

  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .elapsed_ticks      (in_item.elapsed_ticks),
    .unthrottled_ticks  (in_item.unthrottled_ticks),
    .restart            (in_item.restart),
    .tick_rate          (tick_rate),
    .desired_frame_time (dft),
    .min_skip           (min_skip),
    .max_skip           (max_skip),
    .skip_count         (out_item.skip_count),
    .release_throttle   (out_item.release_throttle)
  );
endmodule
